[rtl/core/utf8_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
package utf8_pkg;

    localparam int CP_W      = 21;
    localparam int PARTIAL_W = 15;
    localparam int PEND_W    = 2;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Byte class masks and patterns
    localparam logic [7:0] MASK_ASCII  = 8'h80;
    localparam logic [7:0] MASK_CONT   = 8'hC0;
    localparam logic [7:0] PAT_CONT    = 8'h80;
    localparam logic [7:0] MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] PAT_LEAD2   = 8'hC0;
    localparam logic [7:0] MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] PAT_LEAD3   = 8'hE0;
    localparam logic [7:0] MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] PAT_LEAD4   = 8'hF0;

    // Continuation bytes still expected after each lead
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_LEAD2 = 2'd1;
    localparam logic [PEND_W-1:0] PEND_LEAD3 = 2'd2;
    localparam logic [PEND_W-1:0] PEND_LEAD4 = 2'd3;

    // One decoded result as held in the output queue
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last;
    } t_result;

endpackage

[rtl/core/utf8_stream_decoder_core.sv]
// Top level of the UTF-8 stream decoder: input register, decode logic and result queue.

// Takes one byte per transaction and returns decoded code points. A byte passes
// from the input register through combinational decode logic into a four-entry
// result queue, so bytes are taken at one per cycle while the queue holds two
// or fewer results; a result leaves the queue at most one per cycle. A byte
// that breaks an open sequence yields up to two results (U+FFFD, then the byte's
// own result), but the sequence it breaks began with a lead byte that yielded none,
// so the stream never averages more than one result per byte and the input runs
// at one byte per cycle unless the result side stalls. Lead bytes and unfinished
// sequences produce no result. No overlong, surrogate or range checks are made.
module utf8_stream_decoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_byte_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [utf8_pkg::CP_W-1:0]       o_code_point,
    output logic                            o_is_error,
    output logic                            o_last
);
    import utf8_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;

    // Sequence state
    logic [PARTIAL_W-1:0] r_partial, n_partial;
    logic [PEND_W-1:0]    r_pending, n_pending;

    // Result queue
    t_result             r_queue [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    logic        take_byte;
    logic        in_accept;
    logic        pop;
    logic [1:0]  push_cnt;
    t_result     res0, res1;

    logic        is_cont;
    logic        fresh_emit;
    t_result     fresh_res;
    logic [PARTIAL_W-1:0] fresh_partial;
    logic [PEND_W-1:0]    fresh_pending;
    logic [CP_W-1:0]      joined;

    // Handshake: process the held byte only when the queue can take two results
    assign take_byte  = r_in_valid && (r_count <= QCNT_W'(QDEPTH - 2));
    assign o_in_stall = r_in_valid && !take_byte;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    assign o_out_valid  = (r_count != '0);
    assign o_code_point = r_queue[r_rd_ptr].code_point;
    assign o_is_error   = r_queue[r_rd_ptr].is_error;
    assign o_last       = r_queue[r_rd_ptr].last;

    // Decode a byte with no sequence open
    always_comb begin
        fresh_emit    = 1'b0;
        fresh_res     = '{code_point: '0, is_error: 1'b0, last: 1'b1};
        fresh_partial = '0;
        fresh_pending = PEND_NONE;
        if ((r_byte & MASK_ASCII) == 8'h00) begin
            fresh_emit           = 1'b1;
            fresh_res.code_point = CP_W'(r_byte);
        end else if ((r_byte & MASK_LEAD2) == PAT_LEAD2) begin
            fresh_partial = PARTIAL_W'(r_byte[4:0]);
            fresh_pending = PEND_LEAD2;
        end else if ((r_byte & MASK_LEAD3) == PAT_LEAD3) begin
            fresh_partial = PARTIAL_W'(r_byte[3:0]);
            fresh_pending = PEND_LEAD3;
        end else if ((r_byte & MASK_LEAD4) == PAT_LEAD4) begin
            fresh_partial = PARTIAL_W'(r_byte[2:0]);
            fresh_pending = PEND_LEAD4;
        end else begin
            fresh_emit           = 1'b1;
            fresh_res.code_point = REPLACEMENT_CP;
            fresh_res.is_error   = 1'b1;
        end
    end

    // Decode the held byte against the open sequence
    assign is_cont = ((r_byte & MASK_CONT) == PAT_CONT);
    assign joined  = {r_partial, r_byte[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_pending = r_pending;
        push_cnt  = 2'd0;
        res0      = fresh_res;
        res1      = fresh_res;
        if (take_byte) begin
            if (r_pending == PEND_NONE) begin
                n_partial = fresh_partial;
                n_pending = fresh_pending;
                push_cnt  = {1'b0, fresh_emit};
            end else if (is_cont) begin
                n_pending = r_pending - PEND_W'(1);
                if (r_pending == PEND_LEAD2) begin
                    n_partial = '0;
                    res0      = '{code_point: joined, is_error: 1'b0, last: 1'b1};
                    push_cnt  = 2'd1;
                end else begin
                    n_partial = joined[PARTIAL_W-1:0];
                end
            end else begin
                // Broken sequence: drop it, emit a replacement, then redo the byte
                n_partial = fresh_partial;
                n_pending = fresh_pending;
                res0      = '{code_point: REPLACEMENT_CP, is_error: 1'b1,
                              last: !fresh_emit};
                push_cnt  = fresh_emit ? 2'd2 : 2'd1;
            end
        end
    end

    assign n_count = r_count + QCNT_W'(push_cnt) - QCNT_W'(pop);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_partial  <= '0;
            r_pending  <= PEND_NONE;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_partial <= n_partial;
            r_pending <= n_pending;
            r_wr_ptr  <= r_wr_ptr + QPTR_W'(push_cnt);
            r_rd_ptr  <= r_rd_ptr + QPTR_W'(pop);
            r_count   <= n_count;
        end
    end

    // Hold the input byte; load on acceptance
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte <= i_byte_in;
        end
    end

    // Write results into the queue
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= res1;
        end
    end

`ifndef SYNTH
    // Queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // An accepted byte is held in the input register next cycle
    a_in_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted byte lost");

    // A completed sequence leaves no partial value behind
    a_partial_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_byte && is_cont && r_pending == PEND_LEAD2) |=>
            (r_partial == '0 && r_pending == PEND_NONE))
        else $error("partial value not cleared");
`endif

endmodule

[dv/utf8_stream_decoder_core_test.sv]
// Self-checking testbench for the UTF-8 stream decoder core.
`timescale 1ns / 1ps

module utf8_stream_decoder_core_test;
    import utf8_pkg::*;

    localparam int N_DIR       = 26;
    localparam int RAND_ITEMS  = 424;
    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN       = 16;

    localparam t_result ERR_END = '{REPLACEMENT_CP, 1'b1, 1'b1};
    localparam t_result ERR_MID = '{REPLACEMENT_CP, 1'b1, 1'b0};
    localparam t_result NO_RES  = '0;

    // One row of directed stimulus; typed rows carry their results inline
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic [1:0] n_typed;
        t_result    r0;
        t_result    r1;
    } t_stim_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [7:0]          i_byte_in   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [CP_W-1:0]     o_code_point;
    logic                o_is_error;
    logic                o_last;

    // Decoder state mirrored by the predictor
    logic [PARTIAL_W-1:0] seq_bits = '0;
    logic [PEND_W-1:0]    seq_left = PEND_NONE;
    t_result              decoded [2];
    int                   n_decoded;

    t_result    expected_cps [$];
    logic [7:0] group_bytes [$];

    int n_sent        = 0;
    int n_results     = 0;
    int n_repl        = 0;
    int n_fail        = 0;
    int idle_cycles   = 0;
    bit no_idle       = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    always #6 i_clk = ~i_clk;

    utf8_stream_decoder_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_in    (i_byte_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_point (o_code_point),
        .o_is_error   (o_is_error),
        .o_last       (o_last)
    );

    function automatic t_result cp_res(input logic [CP_W-1:0] cp, input logic err,
                                       input logic lst);
        return '{cp, err, lst};
    endfunction

    function automatic t_stim_row by_model(input logic [7:0] d);
        return '{d, 1'b0, 2'd0, NO_RES, NO_RES};
    endfunction

    function automatic t_stim_row typed_row(input logic [7:0] d, input logic [1:0] n,
                                            input t_result r0, input t_result r1);
        return '{d, 1'b1, n, r0, r1};
    endfunction

    t_stim_row dir_rows [N_DIR] = '{
        typed_row(8'h00, 2'd1, cp_res(21'h000000, 1'b0, 1'b1), NO_RES),
        typed_row(8'h7F, 2'd1, cp_res(21'h00007F, 1'b0, 1'b1), NO_RES),
        typed_row(8'h80, 2'd1, ERR_END, NO_RES),  // stray continuation
        typed_row(8'hBF, 2'd1, ERR_END, NO_RES),
        typed_row(8'hF8, 2'd1, ERR_END, NO_RES),  // invalid lead
        typed_row(8'hFF, 2'd1, ERR_END, NO_RES),
        typed_row(8'hC2, 2'd0, NO_RES, NO_RES),   // lead alone emits nothing
        by_model(8'hA9),
        by_model(8'hE2), by_model(8'h82), by_model(8'hAC),
        by_model(8'hF7), by_model(8'hBF), by_model(8'hBF),
        typed_row(8'hBF, 2'd1, cp_res(21'h1FFFFF, 1'b0, 1'b1), NO_RES),
        // broken sequence: replacement then the ASCII byte
        by_model(8'hC3),
        typed_row(8'h41, 2'd2, ERR_MID, cp_res(21'h000041, 1'b0, 1'b1)),
        // broken sequence by a new lead: replacement alone carries last
        by_model(8'hE1), by_model(8'h80),
        typed_row(8'hC5, 2'd1, ERR_END, NO_RES),
        by_model(8'h80),
        // broken sequence by an invalid lead: two replacements
        by_model(8'hF0), by_model(8'h90),
        typed_row(8'hFF, 2'd2, ERR_MID, ERR_END),
        by_model(8'hDF), by_model(8'hBF)
    };

    // Handle a byte with no sequence open
    task automatic fresh_byte(input logic [7:0] b);
        if ((b & MASK_ASCII) == 8'h00) begin
            decoded[n_decoded] = '{{{(CP_W-8){1'b0}}, b}, 1'b0, 1'b0};
            n_decoded++;
        end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            seq_bits = PARTIAL_W'(b[4:0]);
            seq_left = PEND_LEAD2;
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            seq_bits = PARTIAL_W'(b[3:0]);
            seq_left = PEND_LEAD3;
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            seq_bits = PARTIAL_W'(b[2:0]);
            seq_left = PEND_LEAD4;
        end else begin
            decoded[n_decoded] = ERR_MID;
            n_decoded++;
        end
    endtask

    // Advance the decoder state by one byte and collect its code points
    task automatic decode_byte(input logic [7:0] b);
        logic [CP_W-1:0] v;
        n_decoded = 0;
        if (seq_left != PEND_NONE) begin
            if ((b & MASK_CONT) == PAT_CONT) begin
                v = {seq_bits, b[5:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left == PEND_NONE) begin
                    seq_bits   = '0;
                    decoded[0] = '{v, 1'b0, 1'b0};
                    n_decoded  = 1;
                end else begin
                    seq_bits = v[PARTIAL_W-1:0];
                end
            end else begin
                // drop the open sequence, then treat the byte afresh
                decoded[0] = ERR_MID;
                n_decoded  = 1;
                seq_bits   = '0;
                seq_left   = PEND_NONE;
                fresh_byte(b);
            end
        end else begin
            fresh_byte(b);
        end
        if (n_decoded > 0)
            decoded[n_decoded-1].last = 1'b1;
    endtask

    // Offer one byte, wait for its transaction, then queue its code points
    task automatic send_byte(input t_stim_row row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= row.data;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        decode_byte(row.data);
        if (!row.typed) begin
            for (int i = 0; i < n_decoded; i++)
                expected_cps.push_back(decoded[i]);
        end else begin
            if (row.n_typed > 0) expected_cps.push_back(row.r0);
            if (row.n_typed > 1) expected_cps.push_back(row.r1);
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            1:       return {1'b0, 7'($urandom_range(0, 127))};
            2:       return {3'b110, 5'($urandom_range(0, 31))};
            3:       return {4'b1110, 4'($urandom_range(0, 15))};
            default: return {5'b11110, 3'($urandom_range(0, 7))};
        endcase
    endfunction

    // Build one group: mostly whole sequences, some broken ones and raw noise
    task automatic make_group();
        int kind;
        int len;
        int n_cont;
        logic [7:0] nb;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            len = $urandom_range(1, 4);
            group_bytes.push_back(lead_byte(len));
            for (int i = 1; i < len; i++)
                group_bytes.push_back(cont_byte());
        end else if (kind <= 7) begin
            len    = $urandom_range(2, 4);
            n_cont = $urandom_range(0, len - 2);
            group_bytes.push_back(lead_byte(len));
            for (int i = 0; i < n_cont; i++)
                group_bytes.push_back(cont_byte());
            do nb = 8'($urandom_range(0, 255)); while ((nb & MASK_CONT) == PAT_CONT);
            group_bytes.push_back(nb);
        end else begin
            group_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: random stalls, one long hold on request, check each transaction
    initial begin
        int hold;
        t_result got;
        t_result want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (no_idle) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 7);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            got = '{o_code_point, o_is_error, o_last};
            n_results++;
            if (got.is_error) n_repl++;
            if (expected_cps.size() == 0) begin
                $error("unexpected result: code_point %h is_error %b last %b",
                       got.code_point, got.is_error, got.last);
                n_fail++;
            end else begin
                want = expected_cps.pop_front();
                if (got.code_point !== want.code_point) begin
                    $error("code_point mismatch: expected %h, got %h",
                           want.code_point, got.code_point);
                    n_fail++;
                end
                if (got.is_error !== want.is_error) begin
                    $error("is_error mismatch: expected %b, got %b",
                           want.is_error, got.is_error);
                    n_fail++;
                end
                if (got.last !== want.last) begin
                    $error("last mismatch: expected %b, got %b", want.last, got.last);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: abort when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL utf8_stream_decoder_core");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, random groups, drain
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++)
            send_byte(dir_rows[k]);

        while (n_sent < N_DIR + RAND_ITEMS) begin
            no_idle = ((n_sent / 60) % 4) == 2;
            if (!long_hold_done && n_sent >= 200) begin
                long_hold_req  = 1'b1;
                long_hold_done = 1'b1;
            end
            make_group();
            while (group_bytes.size() > 0)
                send_byte(by_model(group_bytes.pop_front()));
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b1;

        while (expected_cps.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (expected_cps.size() != 0) begin
            $error("%0d code points never arrived", expected_cps.size());
            n_fail++;
        end

        $display("Summary: %0d bytes (directed and random UTF-8 groups) gave %0d code points,",
                 n_sent, n_results);
        $display("  %0d replacements; output held for %0d cycles once to back up the input.",
                 n_repl, LONG_HOLD);
        if (n_fail == 0)
            $display("PASS utf8_stream_decoder_core");
        else
            $display("FAIL utf8_stream_decoder_core");
        $finish;
    end

endmodule
